@@ rtl/rau_pkg.sv @@
// Shared constants and codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
   localparam int DEFAULT_WIDTH = 32;
   localparam int OPER_W        = 32;
   localparam int DEN_OUT_W     = 31;
   localparam int ACTION_W      = 2;
   localparam int STATUS_W      = 2;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_ADD = 2'd0;
   localparam action_type ACT_SUB = 2'd1;
   localparam action_type ACT_MUL = 2'd2;
   localparam action_type ACT_DIV = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_DIVZERO  = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;
endpackage
`default_nettype wire

@@ rtl/rau_chan_if.sv @@
// Request and response channel interfaces of the rational arithmetic unit.
`default_nettype none
interface rau_req_if import rau_pkg::*; ();
   logic                     valid;
   logic                     ready;
   action_type               action;
   logic signed [OPER_W-1:0] lhs_num;
   logic signed [OPER_W-1:0] lhs_den;
   logic signed [OPER_W-1:0] rhs_num;
   logic signed [OPER_W-1:0] rhs_den;
   modport source (output valid, action, lhs_num, lhs_den, rhs_num, rhs_den, input ready);
   modport sink   (input valid, action, lhs_num, lhs_den, rhs_num, rhs_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [OPER_W-1:0] result_num;
   logic [DEN_OUT_W-1:0]     result_den;
   status_type               status;
   modport source (output valid, result_num, result_den, status, input ready);
   modport sink   (input valid, result_num, result_den, status, output ready);
endinterface
`default_nettype wire

@@ rtl/rational_arith_unit.sv @@
// Rational arithmetic unit: add, subtract, multiply, divide of fractions, reduced.
//
// Usage: a request word carries an action and two fractions lhs_num/lhs_den and
// rhs_num/rhs_den; operands are the low OPW = min(WIDTH,32) bits of each field.
// One response word comes back per request: reduced numerator, positive
// denominator and a status (ok, divide by zero, overflow). Fields are zero
// when status is not ok.
// Sequence: a zero denominator or divide by zero skips the arithmetic and goes
// straight to the output register. Otherwise the cross products on the shared
// OPW x OPW multiplier, then the signed add, then the binary GCD (one shift or
// subtract per cycle), then restoring division of numerator and denominator by
// the GCD in parallel, and last the load of the output register.
// Throughput: one request at a time; req ready is high only while idle.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, a finished second result holds in the
// sequencer until the output register frees.
// Reset (synchronous, active high) returns to idle and drops rsp valid.
`default_nettype none
module rational_arith_unit import rau_pkg::*; #(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  wire logic clock,
   input  wire logic reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);
   localparam int OPW = (WIDTH < 32) ? WIDTH : 32;
   localparam int NW  = 2 * OPW;
   localparam int CW  = $clog2(NW);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ADD  = 3'd2;
   localparam logic [2:0] S_GZ   = 3'd3;  // zero test, common twos
   localparam logic [2:0] S_GA   = 3'd4;  // make a odd
   localparam logic [2:0] S_GL   = 3'd5;  // subtract loop
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   localparam logic [NW-1:0] LIM = NW'(1) << (OPW - 1);

   logic [2:0]     state_ff, state_in;
   logic [1:0]     step_ff, step_in;
   action_type     act_ff, act_in;
   logic [OPW-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic           an_ff, an_in, cn_ff, cn_in, rn_ff, rn_in, dz_ff, dz_in;
   logic [NW-1:0]  num_ff, num_in, den_ff, den_in, ga_ff, ga_in, gb_ff, gb_in;
   logic [NW-1:0]  rem1_ff, rem1_in, rem2_ff, rem2_in;
   logic [CW-1:0]  sh_ff, sh_in, cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [OPER_W-1:0]    res_num_ff, res_num_in;
   logic [DEN_OUT_W-1:0] res_den_ff, res_den_in;
   status_type           res_st_ff, res_st_in;

   // operand split of the incoming word
   logic [OPW-1:0] v_an, v_ad, v_cn, v_cd, m_an, m_ad, m_cn, m_cd;
   assign v_an = req_ch.lhs_num[OPW-1:0];
   assign v_ad = req_ch.lhs_den[OPW-1:0];
   assign v_cn = req_ch.rhs_num[OPW-1:0];
   assign v_cd = req_ch.rhs_den[OPW-1:0];
   assign m_an = v_an[OPW-1] ? (~v_an + OPW'(1)) : v_an;
   assign m_ad = v_ad[OPW-1] ? (~v_ad + OPW'(1)) : v_ad;
   assign m_cn = v_cn[OPW-1] ? (~v_cn + OPW'(1)) : v_cn;
   assign m_cd = v_cd[OPW-1] ? (~v_cd + OPW'(1)) : v_cd;

   // shared multiplier
   logic [OPW-1:0] mul_x, mul_y;
   logic [NW-1:0]  prod;
   always_comb begin
      unique case (step_ff)
         2'd0:    begin mul_x = a_ff; mul_y = (act_ff == ACT_MUL) ? c_ff : d_ff; end
         2'd1:    begin mul_x = c_ff; mul_y = b_ff; end
         default: begin mul_x = b_ff; mul_y = (act_ff == ACT_DIV) ? c_ff : d_ff; end
      endcase
   end
   assign prod = {{OPW{1'b0}}, mul_x} * {{OPW{1'b0}}, mul_y};

   // division trial subtracts
   logic [NW:0] r1s, r2s, t1, t2;
   assign r1s = {rem1_ff, num_ff[NW-1]};
   assign r2s = {rem2_ff, den_ff[NW-1]};
   assign t1  = r1s - {1'b0, ga_ff};
   assign t2  = r2s - {1'b0, ga_ff};

   // final check
   logic          fz, frn, fovf;
   logic [NW-1:0] fden;
   logic [OPER_W-1:0] numz;
   assign fz   = (num_ff == '0);
   assign frn  = fz ? 1'b0 : rn_ff;
   assign fden = fz ? NW'(1) : den_ff;
   assign fovf = (fden > LIM - NW'(1)) ||
                 (frn ? (num_ff > LIM) : (num_ff > LIM - NW'(1)));
   assign numz = OPER_W'(num_ff);

   logic sb;
   assign sb = cn_ff ^ (act_ff == ACT_SUB);

   always_comb begin
      state_in = state_ff; step_in = step_ff; act_in = act_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      an_in = an_ff; cn_in = cn_ff; rn_in = rn_ff; dz_in = dz_ff;
      num_in = num_ff; den_in = den_ff; ga_in = ga_ff; gb_in = gb_ff;
      rem1_in = rem1_ff; rem2_in = rem2_ff; sh_in = sh_ff; cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      res_num_in = res_num_ff; res_den_in = res_den_ff; res_st_in = res_st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               act_in = req_ch.action;
               a_in = m_an; b_in = m_ad; c_in = m_cn; d_in = m_cd;
               an_in = v_an[OPW-1] ^ v_ad[OPW-1];
               cn_in = v_cn[OPW-1] ^ v_cd[OPW-1];
               dz_in = (m_ad == '0) || (m_cd == '0) ||
                       ((req_ch.action == ACT_DIV) && (m_cn == '0));
               step_in  = 2'd0;
               state_in = dz_in ? S_FIN : S_MUL;
            end
         end
         S_MUL: begin
            unique case (step_ff)
               2'd0:    num_in = prod;
               2'd1:    gb_in  = prod;
               default: den_in = prod;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) state_in = S_ADD;
         end
         S_ADD: begin
            if (act_ff == ACT_ADD || act_ff == ACT_SUB) begin
               priority if (an_ff == sb) begin
                  rn_in = an_ff; num_in = num_ff + gb_ff;
               end else if (num_ff >= gb_ff) begin
                  rn_in = an_ff; num_in = num_ff - gb_ff;
               end else begin
                  rn_in = sb; num_in = gb_ff - num_ff;
               end
            end else begin
               rn_in = an_ff ^ cn_ff;
            end
            ga_in = num_in; gb_in = den_ff; sh_in = '0;
            state_in = S_GZ;
         end
         S_GZ: begin
            if (ga_ff == '0) begin
               ga_in = gb_ff; rem1_in = '0; rem2_in = '0;
               cnt_in = CW'(NW - 1); state_in = S_DIV;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1; gb_in = gb_ff >> 1; sh_in = sh_ff + CW'(1);
            end else begin
               state_in = S_GA;
            end
         end
         S_GA: begin
            if (!ga_ff[0]) ga_in = ga_ff >> 1;
            else state_in = S_GL;
         end
         S_GL: begin
            priority if (gb_ff == '0) begin
               ga_in = ga_ff << sh_ff; rem1_in = '0; rem2_in = '0;
               cnt_in = CW'(NW - 1); state_in = S_DIV;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_in = gb_ff; gb_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         S_DIV: begin
            if (!t1[NW]) begin rem1_in = t1[NW-1:0];  num_in = {num_ff[NW-2:0], 1'b1}; end
            else         begin rem1_in = r1s[NW-1:0]; num_in = {num_ff[NW-2:0], 1'b0}; end
            if (!t2[NW]) begin rem2_in = t2[NW-1:0];  den_in = {den_ff[NW-2:0], 1'b1}; end
            else         begin rem2_in = r2s[NW-1:0]; den_in = {den_ff[NW-2:0], 1'b0}; end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) state_in = S_FIN;
         end
         default: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               priority if (dz_ff) begin
                  res_st_in = ST_DIVZERO; res_num_in = '0; res_den_in = '0;
               end else if (fovf) begin
                  res_st_in = ST_OVERFLOW; res_num_in = '0; res_den_in = '0;
               end else begin
                  res_st_in  = ST_OK;
                  res_num_in = frn ? (~numz + OPER_W'(1)) : numz;
                  res_den_in = DEN_OUT_W'(fden);
               end
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in; act_ff <= act_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      an_ff <= an_in; cn_ff <= cn_in; rn_ff <= rn_in; dz_ff <= dz_in;
      num_ff <= num_in; den_ff <= den_in; ga_ff <= ga_in; gb_ff <= gb_in;
      rem1_ff <= rem1_in; rem2_ff <= rem2_in; sh_ff <= sh_in; cnt_ff <= cnt_in;
      res_num_ff <= res_num_in; res_den_ff <= res_den_in; res_st_ff <= res_st_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.result_num = res_num_ff;
   assign rsp_ch.result_den = res_den_ff;
   assign rsp_ch.status     = res_st_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after accepting a word");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_st_ff != ST_OK |-> res_num_ff == '0 && res_den_ff == '0)
      else $error("error response with nonzero fields");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_st_ff == ST_OK |-> res_den_ff != '0)
      else $error("ok response with zero denominator");
   a_odd_loop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GL |-> ga_ff[0])
      else $error("gcd loop entered with even operand");
endmodule
`default_nettype wire

@@ dv/rational_arith_unit_tb.sv @@
// Self-checking testbench for the rational arithmetic unit: directed table plus random words.
`timescale 1ns / 100ps
module rational_arith_unit_tb import rau_pkg::*; ();

   localparam int  CYCLE_LIMIT  = 3_000_000;
   localparam int  RANDOM_WORDS = 1330;
   localparam int  DRAIN_CYCLES = 400;   // margin for the longest GCD plus divide
   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

   logic clock;
   logic reset;

   rau_req_if req_ch ();
   rau_rsp_if rsp_ch ();

   rational_arith_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // One request word and the reduced fraction it should give.
   typedef struct {
      action_type  act;
      logic [31:0] ln, ld, rn, rd;
   } operands_type;

   typedef struct {
      logic signed [31:0]    num;
      logic [DEN_OUT_W-1:0]  den;
      status_type            st;
   } fraction_type;

   typedef struct {
      operands_type ops;
      bit           typed;   // expected fraction given in the row
      fraction_type want;
   } table_row_type;

   fraction_type pending_fractions[$];
   int           fail_count = 0;
   int           table_fail_count;
   int unsigned  cycle_count = 0;
   bit           sender_steady;   // no gaps while set

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor: sign/magnitude cross products at 64 bits, then
   // divide out the gcd, then range check against 32-bit signed.
   // ---------------------------------------------------------------
   function automatic logic [63:0] magnitude(input logic [31:0] v);
      logic [31:0] m;
      m = ~v + 32'd1;
      return v[31] ? {32'd0, m} : {32'd0, v};
   endfunction

   function automatic logic [63:0] common_divisor(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic fraction_type reduce_fraction(input operands_type op);
      fraction_type f;
      logic [63:0]  a, b, c, d, p, q, num, den, g;
      bit           sa, sc, sq, sn;
      f = '{num: '0, den: '0, st: ST_OK};
      a = magnitude(op.ln);
      b = magnitude(op.ld);
      c = magnitude(op.rn);
      d = magnitude(op.rd);
      if (b == 0 || d == 0 || (op.act == ACT_DIV && c == 0)) begin
         f.st = ST_DIVZERO;
         return f;
      end
      // fold denominator signs into the numerators
      sa = op.ln[31] ^ op.ld[31];
      sc = op.rn[31] ^ op.rd[31];
      den = b * d;
      case (op.act)
         ACT_ADD, ACT_SUB: begin
            p  = a * d;
            q  = c * b;
            sq = (op.act == ACT_SUB) ? !sc : sc;
            if (sa == sq) begin
               sn = sa; num = p + q;
            end else if (p >= q) begin
               sn = sa; num = p - q;
            end else begin
               sn = sq; num = q - p;
            end
         end
         ACT_MUL: begin
            sn = sa ^ sc; num = a * c;
         end
         default: begin
            sn = sa ^ sc; num = a * d; den = b * c;
         end
      endcase
      g   = common_divisor(num, den);
      num = num / g;
      den = den / g;
      if (num == 0) begin
         sn = 1'b0; den = 64'd1;
      end
      if (den > 64'h7FFF_FFFF || (sn ? num > 64'h8000_0000 : num > 64'h7FFF_FFFF)) begin
         f.st = ST_OVERFLOW;
         return f;
      end
      f.num = sn ? -num[31:0] : num[31:0];
      f.den = den[DEN_OUT_W-1:0];
      return f;
   endfunction

   // ---------------------------------------------------------------
   // Sender: holds one word until accepted, counts it at that edge.
   // ---------------------------------------------------------------
   task automatic send_word(input operands_type op);
      req_ch.valid   <= 1'b1;
      req_ch.action  <= op.act;
      req_ch.lhs_num <= op.ln;
      req_ch.lhs_den <= op.ld;
      req_ch.rhs_num <= op.rn;
      req_ch.rhs_den <= op.rd;
      do @(posedge clock); while (!req_ch.ready);
      pending_fractions.push_back(reduce_fraction(op));
      // random gap after the word, skipped in the steady stretch
      if (!sender_steady && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value(input bit nonzero);
      logic [31:0] v;
      case ($urandom_range(9))
         0, 1:    v = $urandom;                       // full width, every bit
         2: begin
            case ($urandom_range(5))
               0: v = 0;
               1: v = 1;
               2: v = 32'hFFFF_FFFF;
               3: v = INT_MIN;
               4: v = INT_MAX;
               default: v = INT_MIN + 1;
            endcase
         end
         3:       v = $urandom_range(65535) - 32768;  // mid size, cross products fit often
         default: v = $urandom_range(400) - 200;      // small fractions, mostly in range
      endcase
      if (nonzero && v == 0 && $urandom_range(19) != 0) v = 32'd7;
      return v;
   endfunction

   // Receiver and checker.
   always @(posedge clock) begin
      fraction_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         // no stalls while the sender runs without gaps
         if (sender_steady)
            rsp_ch.ready <= 1'b1;
         else
            rsp_ch.ready <= ($urandom_range(99) >= 9);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_fractions.size() == 0) begin
               $error("response word with nothing pending");
               fail_count++;
            end else begin
               want = pending_fractions.pop_front();
               if (rsp_ch.status !== want.st) begin
                  $error("status: expected %0d, got %0d", want.st, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.result_num !== want.num) begin
                  $error("result_num: expected %0d, got %0d", want.num, rsp_ch.result_num);
                  fail_count++;
               end
               if (rsp_ch.result_den !== want.den) begin
                  $error("result_den: expected %0d, got %0d", want.den, rsp_ch.result_den);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rational_arith_unit_tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Directed table: typed rows are readable at a glance.
   // ---------------------------------------------------------------
   table_row_type directed_rows[] = '{
      // 1/2 + 1/3 = 5/6
      '{'{ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3}, 1, '{32'sd5, 31'd6, ST_OK}},
      // 1/2 - 1/3 = 1/6
      '{'{ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd3}, 1, '{32'sd1, 31'd6, ST_OK}},
      // 2/3 * 3/4 = 1/2
      '{'{ACT_MUL, 32'd2, 32'd3, 32'd3, 32'd4}, 1, '{32'sd1, 31'd2, ST_OK}},
      // 1/2 / 1/4 = 2/1
      '{'{ACT_DIV, 32'd1, 32'd2, 32'd1, 32'd4}, 1, '{32'sd2, 31'd1, ST_OK}},
      // zero left denominator
      '{'{ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd3}, 1, '{32'sd0, 31'd0, ST_DIVZERO}},
      // zero right denominator
      '{'{ACT_MUL, 32'd1, 32'd5, 32'd1, 32'd0}, 1, '{32'sd0, 31'd0, ST_DIVZERO}},
      // divide by a zero fraction
      '{'{ACT_DIV, 32'd3, 32'd5, 32'd0, 32'd9}, 1, '{32'sd0, 31'd0, ST_DIVZERO}},
      // zero result: denominator comes back 1
      '{'{ACT_SUB, 32'd3, 32'd7, 32'd3, 32'd7}, 1, '{32'sd0, 31'd1, ST_OK}},
      // negative denominator moves its sign up: 3/-4 * 1/1
      '{'{ACT_MUL, 32'd3, -32'sd4, 32'd1, 32'd1}, 1, '{-32'sd3, 31'd4, ST_OK}},
      // divide by a negative value leaves a positive denominator
      '{'{ACT_DIV, 32'd1, 32'd3, -32'sd2, 32'd1}, 1, '{-32'sd1, 31'd6, ST_OK}},
      // -MIN does not fit
      '{'{ACT_MUL, INT_MIN, 32'd1, -32'sd1, 32'd1}, 1, '{32'sd0, 31'd0, ST_OVERFLOW}},
      '{'{ACT_DIV, INT_MIN, 32'd1, -32'sd1, 32'd1}, 1, '{32'sd0, 31'd0, ST_OVERFLOW}},
      // MAX + 1 does not fit
      '{'{ACT_ADD, INT_MAX, 32'd1, 32'd1, 32'd1}, 1, '{32'sd0, 31'd0, ST_OVERFLOW}},
      // MIN denominator: 2^31 after sign fold, too wide
      '{'{ACT_MUL, 32'd1, INT_MIN, 32'd1, 32'd1}, 1, '{32'sd0, 31'd0, ST_OVERFLOW}},
      // MIN/MIN reduces to 1
      '{'{ACT_MUL, INT_MIN, INT_MIN, 32'd1, 32'd1}, 1, '{32'sd1, 31'd1, ST_OK}},
      // MIN itself still fits
      '{'{ACT_ADD, INT_MIN, 32'd1, 32'd0, 32'd1}, 1, '{32'sd0 + INT_MIN, 31'd1, ST_OK}},
      // MAX/MAX - 1/1 = 0
      '{'{ACT_SUB, INT_MAX, INT_MAX, 32'd1, 32'd1}, 1, '{32'sd0, 31'd1, ST_OK}},
      // wide cross products, predicted
      '{'{ACT_ADD, INT_MAX, INT_MIN, INT_MIN, INT_MAX}, 0, '{0, 0, ST_OK}},
      '{'{ACT_SUB, INT_MIN, INT_MAX, INT_MAX, INT_MIN}, 0, '{0, 0, ST_OK}},
      '{'{ACT_DIV, INT_MAX, 32'hFFFF_FFFF, INT_MIN, INT_MAX}, 0, '{0, 0, ST_OK}},
      '{'{ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, INT_MAX, 32'd3}, 0, '{0, 0, ST_OK}},
      '{'{ACT_ADD, 32'd123457, 32'd65536, -32'sd98765, 32'd65535}, 0, '{0, 0, ST_OK}}
   };

   initial begin
      operands_type op;
      fraction_type typed_want;
      table_fail_count = 0;
      sender_steady    = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_ADD;
      req_ch.lhs_num   = '0;
      req_ch.lhs_den   = '0;
      req_ch.rhs_num   = '0;
      req_ch.rhs_den   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].ops);
         // typed rows must also agree with the predictor
         if (directed_rows[i].typed) begin
            typed_want = pending_fractions[pending_fractions.size() - 1];
            if (typed_want.num !== directed_rows[i].want.num ||
                typed_want.den !== directed_rows[i].want.den ||
                typed_want.st  !== directed_rows[i].want.st) begin
               $error("row %0d: table and predictor disagree", i);
               table_fail_count++;
            end
            pending_fractions[pending_fractions.size() - 1] = directed_rows[i].want;
         end
      end

      // hold off until the directed words have all drained
      req_ch.valid <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         sender_steady = (n >= 300 && n < 500);
         op.act = action_type'($urandom_range(3));
         op.ln  = pick_value(1'b0);
         op.ld  = pick_value(1'b1);
         op.rn  = pick_value(1'b0);
         op.rd  = pick_value(1'b1);
         send_word(op);
      end
      req_ch.valid <= 1'b0;

      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && table_fail_count == 0) begin
         $display("rational_arith_unit_tb OK");
      end else begin
         $display("rational_arith_unit_tb NOT OK");
      end
      $finish;
   end
endmodule
